/* design/manipulability_ellipsoid_length_defines.svh */
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef MANIPULABILITY_ELLIPSOID_LENGTH_DEFINES_SVH
`define MANIPULABILITY_ELLIPSOID_LENGTH_DEFINES_SVH

// Check a property every clock edge outside reset.
`define MEL_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define MEL_NEVER(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* design/mel_pkg.sv */
package mel_pkg;

	localparam int GW       = 40;   // Gram entry width
	localparam int VW       = 256;  // working value width in the back end
	localparam int MW       = 112;  // widest serial multiplier operand
	localparam int NW       = VW + 32;
	localparam int GRAM_N   = 6;
	localparam int QDEPTH   = 2;
	localparam int RF_DEPTH = 21;
	localparam int RAW      = 5;
	localparam int NCW      = 7;
	localparam int PCW      = 5;

	localparam logic [NCW-1:0] N_GRAM = 7'd40;
	localparam logic [NCW-1:0] N_DIR  = 7'd16;
	localparam logic [NCW-1:0] N_VEC  = 7'd96;
	localparam logic [NCW-1:0] N_DET  = 7'd112;

	localparam logic [31:0] LEN_SAT  = 32'hFFFF_FFFF;
	localparam logic [31:0] LEN_ZERO = 32'h0000_0000;

	// Configuration register indexes
	localparam logic [1:0] REG_DIR_X  = 2'd0;
	localparam logic [1:0] REG_DIR_Y  = 2'd1;
	localparam logic [1:0] REG_DIR_Z  = 2'd2;
	localparam logic [1:0] REG_INVERT = 2'd3;

	localparam logic signed [15:0] DIR_X_RESET = 16'sd8192;
	localparam logic signed [15:0] DIR_Y_RESET = 16'sd0;
	localparam logic signed [15:0] DIR_Z_RESET = 16'sd0;

	// Register file slots of the back end
	localparam logic [RAW-1:0] R_M00 = 5'd0;
	localparam logic [RAW-1:0] R_M01 = 5'd1;
	localparam logic [RAW-1:0] R_M02 = 5'd2;
	localparam logic [RAW-1:0] R_M11 = 5'd3;
	localparam logic [RAW-1:0] R_M12 = 5'd4;
	localparam logic [RAW-1:0] R_M22 = 5'd5;
	localparam logic [RAW-1:0] R_V0  = 5'd6;
	localparam logic [RAW-1:0] R_V1  = 5'd7;
	localparam logic [RAW-1:0] R_V2  = 5'd8;
	localparam logic [RAW-1:0] R_C00 = 5'd9;
	localparam logic [RAW-1:0] R_C01 = 5'd10;
	localparam logic [RAW-1:0] R_C02 = 5'd11;
	localparam logic [RAW-1:0] R_C11 = 5'd12;
	localparam logic [RAW-1:0] R_C12 = 5'd13;
	localparam logic [RAW-1:0] R_C22 = 5'd14;
	localparam logic [RAW-1:0] R_DET = 5'd15;
	localparam logic [RAW-1:0] R_A   = 5'd16;
	localparam logic [RAW-1:0] R_B   = 5'd17;
	localparam logic [RAW-1:0] R_C   = 5'd18;
	localparam logic [RAW-1:0] R_P   = 5'd19;
	localparam logic [RAW-1:0] R_Q   = 5'd20;

	typedef struct packed {
		logic signed [15:0] col_x;
		logic signed [15:0] col_y;
		logic signed [15:0] col_z;
		logic               last_column;
	} col_t;

	typedef struct packed {
		logic [31:0] length;
		logic        degenerate;
	} res_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic               invert_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [GW-1:0] m00;
		logic signed [GW-1:0] m01;
		logic signed [GW-1:0] m02;
		logic signed [GW-1:0] m11;
		logic signed [GW-1:0] m12;
		logic signed [GW-1:0] m22;
		cfg_t                 cfg;
	} job_t;

	// One multiply-accumulate step of the back-end program
	typedef struct packed {
		logic [RAW-1:0] src_a;
		logic [RAW-1:0] src_b;
		logic [NCW-1:0] nbits;
		logic           clr;
		logic           sub;
		logic           wr;
		logic [RAW-1:0] dst;
		logic           last;
	} step_t;

	function automatic step_t mk_step(input logic [RAW-1:0] a, input logic [RAW-1:0] b,
			input logic [NCW-1:0] n, input logic clr, input logic sub, input logic wr,
			input logic [RAW-1:0] dst, input logic last);
		step_t s;
		s.src_a = a;
		s.src_b = b;
		s.nbits = n;
		s.clr   = clr;
		s.sub   = sub;
		s.wr    = wr;
		s.dst   = dst;
		s.last  = last;
		return s;
	endfunction

	// Normal mode: cofactors, determinant, adj(M) v, its square norm, det^2.
	// Invert mode: M v and its square norm.
	function automatic step_t prog_step(input logic inv, input logic [PCW-1:0] pc);
		step_t s;
		s = mk_step(R_P, R_P, N_DIR, 1'b0, 1'b0, 1'b0, R_P, 1'b1);
		if (inv) begin
			unique case (pc)
				5'd0:  s = mk_step(R_M00, R_V0, N_DIR, 1'b1, 1'b0, 1'b0, R_A, 1'b0);
				5'd1:  s = mk_step(R_M01, R_V1, N_DIR, 1'b0, 1'b0, 1'b0, R_A, 1'b0);
				5'd2:  s = mk_step(R_M02, R_V2, N_DIR, 1'b0, 1'b0, 1'b1, R_A, 1'b0);
				5'd3:  s = mk_step(R_M01, R_V0, N_DIR, 1'b1, 1'b0, 1'b0, R_B, 1'b0);
				5'd4:  s = mk_step(R_M11, R_V1, N_DIR, 1'b0, 1'b0, 1'b0, R_B, 1'b0);
				5'd5:  s = mk_step(R_M12, R_V2, N_DIR, 1'b0, 1'b0, 1'b1, R_B, 1'b0);
				5'd6:  s = mk_step(R_M02, R_V0, N_DIR, 1'b1, 1'b0, 1'b0, R_C, 1'b0);
				5'd7:  s = mk_step(R_M12, R_V1, N_DIR, 1'b0, 1'b0, 1'b0, R_C, 1'b0);
				5'd8:  s = mk_step(R_M22, R_V2, N_DIR, 1'b0, 1'b0, 1'b1, R_C, 1'b0);
				5'd9:  s = mk_step(R_A, R_A, N_VEC, 1'b1, 1'b0, 1'b0, R_P, 1'b0);
				5'd10: s = mk_step(R_B, R_B, N_VEC, 1'b0, 1'b0, 1'b0, R_P, 1'b0);
				5'd11: s = mk_step(R_C, R_C, N_VEC, 1'b0, 1'b0, 1'b1, R_P, 1'b1);
				default: s = mk_step(R_P, R_P, N_DIR, 1'b0, 1'b0, 1'b0, R_P, 1'b1);
			endcase
		end else begin
			unique case (pc)
				5'd0:  s = mk_step(R_M11, R_M22, N_GRAM, 1'b1, 1'b0, 1'b0, R_C00, 1'b0);
				5'd1:  s = mk_step(R_M12, R_M12, N_GRAM, 1'b0, 1'b1, 1'b1, R_C00, 1'b0);
				5'd2:  s = mk_step(R_M02, R_M12, N_GRAM, 1'b1, 1'b0, 1'b0, R_C01, 1'b0);
				5'd3:  s = mk_step(R_M01, R_M22, N_GRAM, 1'b0, 1'b1, 1'b1, R_C01, 1'b0);
				5'd4:  s = mk_step(R_M01, R_M12, N_GRAM, 1'b1, 1'b0, 1'b0, R_C02, 1'b0);
				5'd5:  s = mk_step(R_M02, R_M11, N_GRAM, 1'b0, 1'b1, 1'b1, R_C02, 1'b0);
				5'd6:  s = mk_step(R_M00, R_M22, N_GRAM, 1'b1, 1'b0, 1'b0, R_C11, 1'b0);
				5'd7:  s = mk_step(R_M02, R_M02, N_GRAM, 1'b0, 1'b1, 1'b1, R_C11, 1'b0);
				5'd8:  s = mk_step(R_M01, R_M02, N_GRAM, 1'b1, 1'b0, 1'b0, R_C12, 1'b0);
				5'd9:  s = mk_step(R_M00, R_M12, N_GRAM, 1'b0, 1'b1, 1'b1, R_C12, 1'b0);
				5'd10: s = mk_step(R_M00, R_M11, N_GRAM, 1'b1, 1'b0, 1'b0, R_C22, 1'b0);
				5'd11: s = mk_step(R_M01, R_M01, N_GRAM, 1'b0, 1'b1, 1'b1, R_C22, 1'b0);
				5'd12: s = mk_step(R_C00, R_M00, N_GRAM, 1'b1, 1'b0, 1'b0, R_DET, 1'b0);
				5'd13: s = mk_step(R_C01, R_M01, N_GRAM, 1'b0, 1'b0, 1'b0, R_DET, 1'b0);
				5'd14: s = mk_step(R_C02, R_M02, N_GRAM, 1'b0, 1'b0, 1'b1, R_DET, 1'b0);
				5'd15: s = mk_step(R_C00, R_V0, N_DIR, 1'b1, 1'b0, 1'b0, R_A, 1'b0);
				5'd16: s = mk_step(R_C01, R_V1, N_DIR, 1'b0, 1'b0, 1'b0, R_A, 1'b0);
				5'd17: s = mk_step(R_C02, R_V2, N_DIR, 1'b0, 1'b0, 1'b1, R_A, 1'b0);
				5'd18: s = mk_step(R_C01, R_V0, N_DIR, 1'b1, 1'b0, 1'b0, R_B, 1'b0);
				5'd19: s = mk_step(R_C11, R_V1, N_DIR, 1'b0, 1'b0, 1'b0, R_B, 1'b0);
				5'd20: s = mk_step(R_C12, R_V2, N_DIR, 1'b0, 1'b0, 1'b1, R_B, 1'b0);
				5'd21: s = mk_step(R_C02, R_V0, N_DIR, 1'b1, 1'b0, 1'b0, R_C, 1'b0);
				5'd22: s = mk_step(R_C12, R_V1, N_DIR, 1'b0, 1'b0, 1'b0, R_C, 1'b0);
				5'd23: s = mk_step(R_C22, R_V2, N_DIR, 1'b0, 1'b0, 1'b1, R_C, 1'b0);
				5'd24: s = mk_step(R_A, R_A, N_VEC, 1'b1, 1'b0, 1'b0, R_P, 1'b0);
				5'd25: s = mk_step(R_B, R_B, N_VEC, 1'b0, 1'b0, 1'b0, R_P, 1'b0);
				5'd26: s = mk_step(R_C, R_C, N_VEC, 1'b0, 1'b0, 1'b1, R_P, 1'b0);
				5'd27: s = mk_step(R_DET, R_DET, N_DET, 1'b1, 1'b0, 1'b1, R_Q, 1'b1);
				default: s = mk_step(R_P, R_P, N_DIR, 1'b0, 1'b0, 1'b0, R_P, 1'b1);
			endcase
		end
		return s;
	endfunction

endpackage

/* design/mel_front.sv */
module mel_front #(
	parameter int MAX_JOINTS = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mel_pkg::col_t col,
	input  mel_pkg::cfg_t cfg,
	output logic          job_push,
	input  logic          job_full,
	output mel_pkg::job_t job
);
	import mel_pkg::*;

	localparam int CW = $clog2(MAX_JOINTS + 1);

	col_t                 col_q;
	logic [2:0]           k_q;
	logic                 busy_q;
	logic                 emit_q;
	logic [CW-1:0]        count_q;
	logic signed [GW-1:0] gram_q [GRAM_N];
	logic signed [15:0]   op_a;
	logic signed [15:0]   op_b;
	logic signed [31:0]   prod;
	logic                 accept;

	assign full   = busy_q || emit_q;
	assign accept = push && !full;

	// Pick the column pair for the current Gram entry
	always_comb begin
		unique case (k_q)
			3'd0: begin op_a = col_q.col_x; op_b = col_q.col_x; end
			3'd1: begin op_a = col_q.col_x; op_b = col_q.col_y; end
			3'd2: begin op_a = col_q.col_x; op_b = col_q.col_z; end
			3'd3: begin op_a = col_q.col_y; op_b = col_q.col_y; end
			3'd4: begin op_a = col_q.col_y; op_b = col_q.col_z; end
			default: begin op_a = col_q.col_z; op_b = col_q.col_z; end
		endcase
	end

	assign prod = op_a * op_b;

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			busy_q  <= 1'b0;
			emit_q  <= 1'b0;
			count_q <= '0;
			for (int i = 0; i < GRAM_N; i++) gram_q[i] <= '0;
		end else begin
			if (accept) begin
				if (count_q < CW'(MAX_JOINTS)) begin
					busy_q  <= 1'b1;
					k_q     <= '0;
					count_q <= count_q + 1'b1;
				end else if (col.last_column) begin
					emit_q <= 1'b1;
				end
			end
			if (busy_q) begin
				gram_q[k_q] <= gram_q[k_q] + GW'(prod);
				k_q         <= k_q + 3'd1;
				if (k_q == 3'(GRAM_N - 1)) begin
					busy_q <= 1'b0;
					emit_q <= col_q.last_column;
				end
			end
			if (emit_q && !job_full) begin
				emit_q  <= 1'b0;
				count_q <= '0;
				for (int i = 0; i < GRAM_N; i++) gram_q[i] <= '0;
			end
		end
	end

	assign job_push = emit_q;
	assign job.m00  = gram_q[0];
	assign job.m01  = gram_q[1];
	assign job.m02  = gram_q[2];
	assign job.m11  = gram_q[3];
	assign job.m12  = gram_q[4];
	assign job.m22  = gram_q[5];
	assign job.cfg  = cfg;

endmodule

/* design/mel_queue.sv */
`include "manipulability_ellipsoid_length_defines.svh"

module mel_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mel_pkg::job_t din,
	input  logic          pop,
	output logic          empty,
	output mel_pkg::job_t dout
);
	import mel_pkg::*;

	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == QCW'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`MEL_NEVER(a_queue_over, cnt_q > QCW'(QDEPTH), "queue count beyond depth")
	`MEL_ASSERT(a_queue_fill, (do_push && !do_pop) |=> !empty, "pushed entry lost")

endmodule

/* design/mel_back.sv */
`include "manipulability_ellipsoid_length_defines.svh"

module mel_back #(
	parameter int FRAC_BITS = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_empty,
	output logic          job_pop,
	input  mel_pkg::job_t job,
	output mel_pkg::res_t res,
	output logic          empty,
	input  logic          pop
);
	import mel_pkg::*;

	localparam int P_SHIFT   = 2 * FRAC_BITS;
	localparam int ONE_SHIFT = 32 + 6 * FRAC_BITS;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_ISSUE = 4'd2;
	localparam logic [3:0] ST_FETCH = 4'd3;
	localparam logic [3:0] ST_RUN   = 4'd4;
	localparam logic [3:0] ST_FIN1  = 4'd5;
	localparam logic [3:0] ST_FIN2  = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_SQRT  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0]     state_q;
	job_t           job_q;
	logic [3:0]     ld_q;
	logic [PCW-1:0] pc_q;
	logic [NCW-1:0] it_q;
	logic [VW-1:0]  a_sh_q;
	logic [MW-1:0]  b_sh_q;
	logic [VW-1:0]  acc_q;
	logic           det_zero_q;
	logic [VW-1:0]  den_q;
	logic [VW:0]    rem_q;
	logic [63:0]    numlo_q;
	logic [63:0]    quo_q;
	logic [31:0]    root_q;
	res_t           pend_q;
	res_t           res_q;
	logic           res_valid_q;

	logic [VW-1:0]  rf_mem [RF_DEPTH];
	logic [VW-1:0]  rda_q;
	logic [VW-1:0]  rdb_q;
	logic [RAW-1:0] ra;
	logic [RAW-1:0] rb;
	logic           we;
	logic [RAW-1:0] waddr;
	logic [VW-1:0]  wdata;
	logic [VW-1:0]  ld_val;

	step_t          step;
	logic           last_it;
	logic           do_sub;
	logic [VW-1:0]  acc_d;

	logic [VW-1:0]  den_w;
	logic [NW-1:0]  num_w;
	logic [VW:0]    hi_w;
	logic [VW:0]    rem2;
	logic           ge;
	logic [31:0]    cand;
	logic [63:0]    sq;
	logic           slot_free;

	assign step    = prog_step(job_q.cfg.invert_mode, pc_q);
	assign last_it = (it_q == step.nbits - 7'd1);
	assign do_sub  = last_it ^ step.sub;

	// One shift-add step; the top multiplier bit carries negative weight
	always_comb begin
		acc_d = acc_q;
		if (b_sh_q[0]) begin
			acc_d = do_sub ? (acc_q - a_sh_q) : (acc_q + a_sh_q);
		end
	end

	always_comb begin
		unique case (ld_q)
			4'd0: ld_val = VW'(job_q.m00);
			4'd1: ld_val = VW'(job_q.m01);
			4'd2: ld_val = VW'(job_q.m02);
			4'd3: ld_val = VW'(job_q.m11);
			4'd4: ld_val = VW'(job_q.m12);
			4'd5: ld_val = VW'(job_q.m22);
			4'd6: ld_val = VW'(job_q.cfg.dir_x);
			4'd7: ld_val = VW'(job_q.cfg.dir_y);
			4'd8: ld_val = VW'(job_q.cfg.dir_z);
			default: ld_val = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = step.dst;
		wdata = acc_d;
		if (state_q == ST_LOAD) begin
			we    = 1'b1;
			waddr = RAW'(ld_q);
			wdata = ld_val;
		end else if (state_q == ST_RUN && last_it && step.wr) begin
			we = 1'b1;
		end
	end

	assign ra = (state_q == ST_FIN1) ? R_P : step.src_a;
	assign rb = (state_q == ST_FIN1) ? R_Q : step.src_b;

	always_ff @(posedge clk) begin
		if (we) begin
			rf_mem[waddr] <= wdata;
		end
		rda_q <= rf_mem[ra];
		rdb_q <= rf_mem[rb];
	end

	// Divider operands: q / p, or 1 / p in invert mode, with the fixed-point scale folded in
	always_comb begin
		if (job_q.cfg.invert_mode) begin
			den_w = rda_q;
			num_w = NW'(1) << ONE_SHIFT;
		end else begin
			den_w = rda_q << P_SHIFT;
			num_w = {rdb_q, 32'b0};
		end
		hi_w = (VW + 1)'(num_w[NW-1:64]);
	end

	assign rem2 = {rem_q[VW-1:0], numlo_q[63]};
	assign ge   = (rem2 >= {1'b0, den_q});
	assign cand = root_q | (32'd1 << it_q[4:0]);
	assign sq   = cand * cand;

	assign slot_free = !res_valid_q || pop;
	assign job_pop   = (state_q == ST_IDLE) && !job_empty;

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		unique case (state_q)
			ST_FETCH: begin
				a_sh_q <= rda_q;
				b_sh_q <= rdb_q[MW-1:0];
				if (step.clr) acc_q <= '0;
			end
			ST_RUN: begin
				acc_q  <= acc_d;
				a_sh_q <= a_sh_q << 1;
				b_sh_q <= b_sh_q >> 1;
			end
			ST_FIN2: begin
				den_q   <= den_w;
				rem_q   <= hi_w;
				numlo_q <= num_w[63:0];
			end
			ST_DIV: begin
				rem_q   <= ge ? (rem2 - {1'b0, den_q}) : rem2;
				numlo_q <= numlo_q << 1;
				quo_q   <= {quo_q[62:0], ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ld_q        <= '0;
			pc_q        <= '0;
			it_q        <= '0;
			det_zero_q  <= 1'b0;
			root_q      <= '0;
			pend_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one loads in the same cycle
			if (pop && res_valid_q && !(state_q == ST_DONE && slot_free))
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						ld_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + 4'd1;
					if (ld_q == 4'd8) begin
						pc_q    <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_FETCH;
				ST_FETCH: begin
					it_q    <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					it_q <= it_q + 7'd1;
					if (last_it) begin
						if (step.wr && step.dst == R_DET) det_zero_q <= (acc_d == '0);
						if (step.last) begin
							state_q <= ST_FIN1;
						end else begin
							pc_q    <= pc_q + 5'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: begin
					// Singular matrix, then zero denominator, then overflow
					priority if (!job_q.cfg.invert_mode && det_zero_q) begin
						pend_q  <= '{length: LEN_ZERO, degenerate: 1'b1};
						state_q <= ST_DONE;
					end else if (den_w == '0) begin
						pend_q  <= '{length: LEN_SAT, degenerate: 1'b1};
						state_q <= ST_DONE;
					end else if (hi_w >= {1'b0, den_w}) begin
						pend_q  <= '{length: LEN_SAT, degenerate: 1'b0};
						state_q <= ST_DONE;
					end else begin
						it_q    <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (it_q == 7'd63) begin
						it_q    <= 7'd31;
						root_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						it_q <= it_q + 7'd1;
					end
				end
				ST_SQRT: begin
					if (sq <= quo_q) root_q <= cand;
					it_q <= it_q - 7'd1;
					if (it_q == 7'd0) begin
						pend_q  <= '{length: (sq <= quo_q) ? cand : root_q, degenerate: 1'b0};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						res_q       <= pend_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res   = res_q;
	assign empty = !res_valid_q;

	`MEL_ASSERT(a_res_hold, (res_valid_q && !pop) |=> (res_valid_q && $stable(res_q)),
		"waiting result changed")
	`MEL_ASSERT(a_run_count, (state_q == ST_RUN) |-> (it_q < step.nbits),
		"multiplier ran past operand width")

endmodule

/* design/manipulability_ellipsoid_length.sv */
// Directional radius of the manipulability ellipsoid. Push one Jacobian column
// (Q3.13 x, y, z) per request; the front end sums the Gram matrix M = J*J^T with
// one shared 16x16 multiplier, so after each column is accepted it is
// multiply-accumulated into the six Gram entries in turn, and full is high
// meanwhile. Columns past MAX_JOINTS are taken but not summed. A request with
// last_column set hands M and a snapshot of the direction and mode to a
// two-entry queue, then the front end is free for the next matrix. The back end
// evaluates the closed form exactly with a bit-serial shift-add multiplier (one
// operand bit per cycle), a 64-step restoring divider and a 32-step square-root
// search, and delivers length (unsigned Q16.16, saturating) and degenerate in
// the result register. A singular M in normal mode gives length 0 with
// degenerate set; a zero denominator gives all ones with degenerate set. Write
// the configuration only while no matrix is in flight.
module manipulability_ellipsoid_length #(
	parameter int MAX_JOINTS = 7,
	parameter int FRAC_BITS  = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mel_pkg::col_t col,
	output logic          empty,
	input  logic          pop,
	output mel_pkg::res_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import mel_pkg::*;

	cfg_t cfg_q;
	logic job_push;
	logic job_full;
	job_t job_in;
	logic job_empty;
	logic job_pop;
	job_t job_out;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dir_x       <= DIR_X_RESET;
			cfg_q.dir_y       <= DIR_Y_RESET;
			cfg_q.dir_z       <= DIR_Z_RESET;
			cfg_q.invert_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIR_X:  cfg_q.dir_x       <= cfg_data;
				REG_DIR_Y:  cfg_q.dir_y       <= cfg_data;
				REG_DIR_Z:  cfg_q.dir_z       <= cfg_data;
				REG_INVERT: cfg_q.invert_mode <= cfg_data[0];
			endcase
		end
	end

	// Front end: accept columns, accumulate M, hand off on the last column
	mel_front #(
		.MAX_JOINTS(MAX_JOINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.col      (col),
		.cfg      (cfg_q),
		.job_push (job_push),
		.job_full (job_full),
		.job      (job_in)
	);

	// Decouple the two halves so the front end keeps accepting
	mel_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.full   (job_full),
		.din    (job_in),
		.pop    (job_pop),
		.empty  (job_empty),
		.dout   (job_out)
	);

	// Back end: exact closed-form radius and the result register
	mel_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job       (job_out),
		.res       (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
